// ===== design/frm8_pkg.sv =====
// Shared types and constants for the fixed-range 16-bit to 8-bit pixel scaler.
`default_nettype none

package frm8_pkg;

    localparam int unsigned PIX_IN_W   = 16;
    localparam int unsigned PIX_OUT_W  = 8;
    localparam int unsigned DEPTH_W    = 5;
    localparam int unsigned FS_W       = 17;
    localparam int unsigned MAX_W      = 16;
    localparam int unsigned NUM_W      = 24;
    localparam int unsigned QUOT_W     = 8;
    localparam int unsigned APB_DATA_W = 32;
    localparam int unsigned CFG_ADDR_W = 4;

    localparam logic [PIX_OUT_W-1:0] PIX_SCALE      = 8'd255;
    localparam logic [DEPTH_W-1:0]   DEPTH_MAX      = 5'd16;
    localparam logic [DEPTH_W-1:0]   BIT_DEPTH_RST  = 5'd12;
    localparam logic [FS_W-1:0]      FULL_SCALE_RST = 17'd4095;

    // Register index, taken from paddr[3:2].
    typedef enum logic [1:0] {
        CFG_BIT_DEPTH  = 2'd0,
        CFG_FULL_SCALE = 2'd1,
        CFG_PASSTHRU   = 2'd2
    } t_cfg_reg;

    // Dividend, divisor and error flag handed to the divider pipeline.
    typedef struct packed {
        logic [NUM_W-1:0] num;
        logic [MAX_W-1:0] dvs;
        logic             err;
    } t_div_req;

    // Quotient and error flag leaving the divider pipeline.
    typedef struct packed {
        logic [QUOT_W-1:0] quot;
        logic              err;
    } t_div_rsp;

endpackage

`default_nettype wire

// ===== design/frm8_if.sv =====
// Stream interfaces for the pixel input and pixel output channels.
`default_nettype none

interface frm8_in_if import frm8_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [PIX_IN_W-1:0] pixel_in;

    modport source (output valid, output pixel_in, input ready);
    modport sink   (input valid, input pixel_in, output ready);
endinterface

interface frm8_out_if import frm8_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic [PIX_OUT_W-1:0] pixel_out;
    logic                 config_error;

    modport source (output valid, output pixel_out, output config_error, input ready);
    modport sink   (input valid, input pixel_out, input config_error, output ready);
endinterface

`default_nettype wire

// ===== design/frm8_div.sv =====
// Pipelined restoring divider: one quotient bit per register stage.
`default_nettype none

module frm8_div import frm8_pkg::*; (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_valid,
    output logic          o_ready,
    input  wire t_div_req i_req,
    output logic          o_valid,
    input  wire logic     i_ready,
    output t_div_rsp      o_rsp
);

    logic                  r_v   [QUOT_W];
    logic [NUM_W-1:0]      r_rem [QUOT_W];
    logic [MAX_W-1:0]      r_dvs [QUOT_W];
    logic [QUOT_W-1:0]     r_q   [QUOT_W];
    logic                  r_err [QUOT_W];

    logic                  src_v   [QUOT_W];
    logic [NUM_W-1:0]      src_rem [QUOT_W];
    logic [MAX_W-1:0]      src_dvs [QUOT_W];
    logic [QUOT_W-1:0]     src_q   [QUOT_W];
    logic                  src_err [QUOT_W];
    logic                  en      [QUOT_W];

    // A stage moves when it is empty or the stage after it moves.
    always_comb begin
        en[QUOT_W-1] = !r_v[QUOT_W-1] || i_ready;
        for (int s = QUOT_W - 2; s >= 0; s--) begin
            en[s] = !r_v[s] || en[s+1];
        end
    end

    genvar s;
    generate
        for (s = 0; s < QUOT_W; s++) begin : g_stage
            logic [NUM_W-1:0]  n_rem;
            logic [QUOT_W-1:0] n_q;
            logic [NUM_W-1:0]  dvs_sh;

            if (s == 0) begin : g_first
                assign src_v[s]   = i_valid;
                assign src_rem[s] = i_req.num;
                assign src_dvs[s] = i_req.dvs;
                assign src_q[s]   = '0;
                assign src_err[s] = i_req.err;
            end else begin : g_next
                assign src_v[s]   = r_v[s-1];
                assign src_rem[s] = r_rem[s-1];
                assign src_dvs[s] = r_dvs[s-1];
                assign src_q[s]   = r_q[s-1];
                assign src_err[s] = r_err[s-1];
            end

            // Try to take the divisor, shifted to this bit's weight, out of the remainder.
            always_comb begin
                dvs_sh = NUM_W'(src_dvs[s]) << (QUOT_W - 1 - s);
                n_q    = src_q[s];
                n_rem  = src_rem[s];
                if (src_rem[s] >= dvs_sh) begin
                    n_rem              = src_rem[s] - dvs_sh;
                    n_q[QUOT_W-1-s]    = 1'b1;
                end
            end

            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_v[s] <= 1'b0;
                end else if (en[s]) begin
                    r_v[s] <= src_v[s];
                end
            end

            always_ff @(posedge i_clk) begin
                if (en[s] && src_v[s]) begin
                    r_rem[s] <= n_rem;
                    r_dvs[s] <= src_dvs[s];
                    r_q[s]   <= n_q;
                    r_err[s] <= src_err[s];
                end
            end
        end
    endgenerate

    assign o_ready    = en[0];
    assign o_valid    = r_v[QUOT_W-1];
    assign o_rsp.quot = r_q[QUOT_W-1];
    assign o_rsp.err  = r_err[QUOT_W-1];

endmodule

`default_nettype wire

// ===== design/fixed_range_mono16_to_mono8.sv =====
// Top level of the fixed-range 16-bit to 8-bit monochrome pixel scaler.
//
// One 16-bit camera pixel enters per transfer on i_pix and one 8-bit display
// pixel with an error flag leaves per transfer on o_pix, in the same order.
// The pixel is clamped to a full-scale maximum and scaled as
// (p*255 + max/2) / max. The maximum is the full_scale register, or
// (1 << bit_depth) - 1 when that register is zero. In pass-through mode the
// low byte of the pixel is forwarded. Otherwise a bit depth outside 1 to 16
// or a full scale above 65535 gives pixel 0 with config_error set.
// The APB port holds bit_depth at 0x0, full_scale at 0x4 and
// passthrough_8bit at 0x8; write it only while no pixels are in flight.
// An input transfer passes a clamp stage, a multiply-add stage and eight
// divider stages, each resolving one quotient bit, before its result shows
// on o_pix. A new pixel is taken every cycle until a receiver stall backs up to i_pix.
// Reset clears all valid bits and loads the register reset values. When the
// receiver stalls, the result holds in the last stage and the stages behind
// it keep filling their empty slots before i_pix.ready drops.
`default_nettype none

module fixed_range_mono16_to_mono8 import frm8_pkg::*; (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    frm8_in_if.sink                    i_pix,
    frm8_out_if.source                 o_pix,
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [CFG_ADDR_W-1:0] paddr,
    input  wire logic [APB_DATA_W-1:0] pwdata,
    output logic      [APB_DATA_W-1:0] prdata,
    output logic                       pready
);

    // Configuration registers.
    logic [DEPTH_W-1:0] r_bit_depth;
    logic [FS_W-1:0]    r_full_scale;
    logic               r_pass;
    logic               cfg_wr;
    t_cfg_reg           cfg_sel;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite;
    assign cfg_sel = t_cfg_reg'(paddr[3:2]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bit_depth  <= BIT_DEPTH_RST;
            r_full_scale <= FULL_SCALE_RST;
            r_pass       <= 1'b0;
        end else if (cfg_wr) begin
            case (cfg_sel)
                CFG_BIT_DEPTH:  r_bit_depth  <= pwdata[DEPTH_W-1:0];
                CFG_FULL_SCALE: r_full_scale <= pwdata[FS_W-1:0];
                CFG_PASSTHRU:   r_pass       <= pwdata[0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (cfg_sel)
            CFG_BIT_DEPTH:  prdata = APB_DATA_W'(r_bit_depth);
            CFG_FULL_SCALE: prdata = APB_DATA_W'(r_full_scale);
            CFG_PASSTHRU:   prdata = APB_DATA_W'(r_pass);
            default:        prdata = '0;
        endcase
    end

    // Stage A: pick the maximum, check the configuration and clamp the pixel.
    // Pass-through is folded into the same datapath as pixel = low byte and
    // maximum = 255, which the divider returns unchanged. An error feeds a
    // zero pixel over a maximum of one so the quotient comes out zero.
    logic [FS_W-1:0]     depth_sh;
    logic [MAX_W-1:0]    max_sel;
    logic                cfg_bad;
    logic [MAX_W-1:0]    n_a_pix;
    logic [MAX_W-1:0]    n_a_max;
    logic                n_a_err;
    logic                r_a_v;
    logic [MAX_W-1:0]    r_a_pix;
    logic [MAX_W-1:0]    r_a_max;
    logic                r_a_err;

    // Stage B: form the dividend p*255 + max/2.
    logic                r_b_v;
    t_div_req            r_b_req;
    t_div_req            n_b_req;

    logic                en_a;
    logic                en_b;
    logic                div_ready;
    t_div_rsp            div_rsp;

    always_comb begin
        depth_sh = FS_W'(1) << r_bit_depth;
        max_sel  = (r_full_scale == '0) ? MAX_W'(depth_sh - FS_W'(1))
                                         : r_full_scale[MAX_W-1:0];
        cfg_bad  = (r_bit_depth == '0) || (r_bit_depth > DEPTH_MAX) || r_full_scale[FS_W-1];
        n_a_err  = 1'b0;
        if (r_pass) begin
            n_a_pix = MAX_W'(i_pix.pixel_in[PIX_OUT_W-1:0]);
            n_a_max = MAX_W'(PIX_SCALE);
        end else if (cfg_bad) begin
            n_a_pix = '0;
            n_a_max = MAX_W'(1);
            n_a_err = 1'b1;
        end else begin
            n_a_max = max_sel;
            n_a_pix = (i_pix.pixel_in > max_sel) ? max_sel : i_pix.pixel_in;
        end
    end

    always_comb begin
        n_b_req.num = NUM_W'(r_a_pix) * NUM_W'(PIX_SCALE) + NUM_W'(r_a_max >> 1);
        n_b_req.dvs = r_a_max;
        n_b_req.err = r_a_err;
    end

    assign en_b        = !r_b_v || div_ready;
    assign en_a        = !r_a_v || en_b;
    assign i_pix.ready = en_a;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_v <= 1'b0;
            r_b_v <= 1'b0;
        end else begin
            if (en_a) begin
                r_a_v <= i_pix.valid;
            end
            if (en_b) begin
                r_b_v <= r_a_v;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en_a && i_pix.valid) begin
            r_a_pix <= n_a_pix;
            r_a_max <= n_a_max;
            r_a_err <= n_a_err;
        end
        if (en_b && r_a_v) begin
            r_b_req <= n_b_req;
        end
    end

    frm8_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_b_v),
        .o_ready (div_ready),
        .i_req   (r_b_req),
        .o_valid (o_pix.valid),
        .i_ready (o_pix.ready),
        .o_rsp   (div_rsp)
    );

    assign o_pix.pixel_out    = div_rsp.quot;
    assign o_pix.config_error = div_rsp.err;

endmodule

`default_nettype wire

// ===== design/frm8_chk.sv =====
// Port-level checker for the pixel scaler, bound to its top level.
`default_nettype none

module frm8_chk import frm8_pkg::*; (
    input wire logic                  i_clk,
    input wire logic                  i_rst_n,
    input wire logic                  i_out_valid,
    input wire logic                  i_out_ready,
    input wire logic [PIX_OUT_W-1:0]  i_pixel_out,
    input wire logic                  i_config_error,
    input wire logic                  i_psel,
    input wire logic                  i_penable,
    input wire logic                  i_pwrite,
    input wire logic [CFG_ADDR_W-1:0] i_paddr,
    input wire logic [APB_DATA_W-1:0] i_pwdata
);

    // Mirror of the pass-through register as written on the APB port.
    logic r_pass;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pass <= 1'b0;
        end else if (i_psel && i_penable && i_pwrite && t_cfg_reg'(i_paddr[3:2]) == CFG_PASSTHRU) begin
            r_pass <= i_pwdata[0];
        end
    end

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=>
            i_out_valid && $stable(i_pixel_out) && $stable(i_config_error))
        else $error("stalled result changed or vanished");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result presented right after reset");

    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_config_error |-> i_pixel_out == '0)
        else $error("error result carries a nonzero pixel");

    a_pass_no_err: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && r_pass |-> !i_config_error)
        else $error("error flagged in pass-through mode");

endmodule

bind fixed_range_mono16_to_mono8 frm8_chk u_frm8_chk (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_out_valid    (o_pix.valid),
    .i_out_ready    (o_pix.ready),
    .i_pixel_out    (o_pix.pixel_out),
    .i_config_error (o_pix.config_error),
    .i_psel         (psel),
    .i_penable      (penable),
    .i_pwrite       (pwrite),
    .i_paddr        (paddr),
    .i_pwdata       (pwdata)
);

`default_nettype wire
